/* sv/lir_pkg.sv */
// ----------------------------------------------------------------------------
// Linear interpolation resampler package
// Shared types and fixed constants of the resampler: register indexes, reset
// values, result limit and the control bundle of the output stage.
// ----------------------------------------------------------------------------
package lir_pkg;

    // Register widths as fixed by the register map.
    localparam int STEP_W  = 21;
    localparam int SCALE_W = 20;
    localparam int CHAN_W  = 3;

    // Register indexes (word address bits [3:2]).
    localparam logic [1:0] REG_SOURCE_STEP   = 2'd0;
    localparam logic [1:0] REG_LENGTH_SCALE  = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;
    localparam logic [1:0] REG_BYPASS        = 2'd3;

    localparam logic [STEP_W-1:0]  STEP_RST  = 21'd65536;
    localparam logic [SCALE_W-1:0] SCALE_RST = 20'd65536;
    localparam logic [CHAN_W-1:0]  CHAN_RST  = 3'd2;

    // At most this many results leave for one input item.
    localparam int MAX_RESULTS = 20;
    localparam int CNT_W       = 5;

    // Phase fraction width beyond the frame count, and output counter width.
    localparam int FRAC_W = 16;
    localparam int SENT_W = 24;

    typedef struct packed {
        logic load;
        logic last;
    } t_emit_ctl;

endpackage

/* sv/lir_lane.sv */
// ----------------------------------------------------------------------------
// Resampler channel lane
// Blends one channel between the previous and current frame with a 16-bit
// fractional weight, rounding halves up: prev + (cur - prev) * w.
// ----------------------------------------------------------------------------
module lir_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic signed [SAMPLE_BITS-1:0] i_prev,
    input  logic signed [SAMPLE_BITS-1:0] i_cur,
    input  logic        [15:0]            i_weight,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);
    import lir_pkg::*;

    localparam int DW = SAMPLE_BITS + 1;
    localparam int PW = SAMPLE_BITS + 18;
    localparam int SW = SAMPLE_BITS + 19;

    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod;
    logic signed [SW-1:0] sum;

    assign diff = DW'(i_cur) - DW'(i_prev);
    assign prod = PW'(diff) * PW'($signed({1'b0, i_weight}));
    // The blend always lands within the sample range, so the floor of the
    // shifted sum can be taken by a plain part-select.
    assign sum  = (SW'(i_prev) <<< FRAC_W) + SW'(prod) + SW'(32768);
    assign o_sample = sum[SAMPLE_BITS+FRAC_W-1:FRAC_W];

endmodule

/* sv/lir_merge.sv */
// ----------------------------------------------------------------------------
// Resampler merge and output stage
// Gathers the lane results into one output item, clears unused channels and
// holds the item in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module lir_merge #(
    parameter int MAX_CHANNELS = 4,
    parameter int SAMPLE_BITS  = 16,
    parameter int TDATA_W      = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lir_pkg::t_emit_ctl                    i_ctl,
    input  logic [MAX_CHANNELS-1:0]               i_lane_en,
    input  logic [MAX_CHANNELS*SAMPLE_BITS-1:0]   i_lane_data,
    input  logic                                  i_ready,
    output logic                                  o_valid,
    output logic [TDATA_W-1:0]                    o_data,
    output logic                                  o_last,
    output logic                                  o_free
);
    import lir_pkg::*;

    localparam int DW = MAX_CHANNELS * SAMPLE_BITS;

    logic               r_valid;
    logic [TDATA_W-1:0] r_data;
    logic               r_last;
    logic [DW-1:0]      packed_data;

    always_comb begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            packed_data[c*SAMPLE_BITS +: SAMPLE_BITS] =
                i_lane_en[c] ? i_lane_data[c*SAMPLE_BITS +: SAMPLE_BITS] : '0;
        end
    end

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= TDATA_W'(packed_data);
            r_last <= i_ctl.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

/* sv/linear_interp_resampler.sv */
// ----------------------------------------------------------------------------
// Linear interpolation resampler
// Converts a stream of audio frames to another rate by linear interpolation.
// ----------------------------------------------------------------------------
// Usage:
// Frames enter on the s_axis channel, one item per frame, channel 0 in the
// lowest bits of tdata; tlast marks the final frame of a stream. Resampled
// frames leave on m_axis, tlast set on the final output frame of a stream.
// Registers on the APB port: source step, length scale, channel count and
// bypass, at byte addresses 0, 4, 8 and 12; change them only while idle.
// One item is worked on at a time. After an accepted frame the block emits
// one result per cycle from the output register while the receiver takes
// them; the first result passes the sequencer state and the output register
// (on a final frame the output count needs a multiply and a subtract first,
// in S_PROD and S_KCALC). A frame yields at most 20 results. The emit loop of the
// control sequencer sets this rate: all channel lanes blend in the same
// cycle. A stalled receiver holds the output register and the loop waits.
// Synchronous reset clears the stream state and loads the register defaults.
// ----------------------------------------------------------------------------
module linear_interp_resampler #(
    parameter int MAX_CHANNELS     = 4,
    parameter int SAMPLE_BITS      = 16,
    parameter int FRAME_COUNT_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // Input frames
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // in_ch0 .. in_chN, SAMPLE_BITS each, lowest channel first; zero padding
    input  logic [((MAX_CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                  s_axis_tlast,
    // Output frames
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_ch0 .. out_chN, SAMPLE_BITS each, lowest channel first; zero padding
    output logic [((MAX_CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);
    import lir_pkg::*;

    localparam int DW    = MAX_CHANNELS * SAMPLE_BITS;
    localparam int TDW   = ((DW + 7) / 8) * 8;
    localparam int FW    = FRAME_COUNT_BITS;
    localparam int PW    = FW + FRAC_W;
    localparam int PRODW = FW + 1 + SCALE_W;
    localparam int TOTW  = PRODW - 15;
    localparam int KW    = ((TOTW > SENT_W) ? TOTW : SENT_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PROD  = 4'b0010,
        S_KCALC = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    // Configuration registers
    logic [STEP_W-1:0]  r_step;
    logic [SCALE_W-1:0] r_scale;
    logic [CHAN_W-1:0]  r_chan;
    logic               r_bypass;

    // Stream state
    t_state                       r_state, n_state;
    logic signed [SAMPLE_BITS-1:0] r_prev [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_cur  [MAX_CHANNELS];
    logic [PW-1:0]                r_phase;
    logic [FW-1:0]                r_frames;
    logic [SENT_W-1:0]            r_sent;
    logic                         r_byp_item;
    logic                         r_last_item;
    logic                         r_last_in;
    logic [CNT_W-1:0]             r_cnt;
    logic [CNT_W-1:0]             r_k;
    logic [PRODW-1:0]             r_prod;

    logic                    in_acc;
    logic                    cfg_wr;
    logic                    m_free;
    logic                    want;
    logic                    last_flag;
    t_emit_ctl               emit_ctl;
    logic [PW-1:0]           limit;
    logic [PW:0]             phase_sum;
    logic [PW-1:0]           phase_next;
    logic [PRODW:0]          rnd;
    logic [TOTW-1:0]         total;
    logic [KW-1:0]           total_e;
    logic [KW-1:0]           kdiff;
    logic [MAX_CHANNELS-1:0] lane_en;
    logic [DW-1:0]           lane_y;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= STEP_RST;
            r_scale  <= SCALE_RST;
            r_chan   <= CHAN_RST;
            r_bypass <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SOURCE_STEP:   r_step   <= pwdata[STEP_W-1:0];
                REG_LENGTH_SCALE:  r_scale  <= pwdata[SCALE_W-1:0];
                REG_CHANNEL_COUNT: r_chan   <= pwdata[CHAN_W-1:0];
                REG_BYPASS:        r_bypass <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SOURCE_STEP:   prdata = 32'(r_step);
            REG_LENGTH_SCALE:  prdata = 32'(r_scale);
            REG_CHANNEL_COUNT: prdata = 32'(r_chan);
            REG_BYPASS:        prdata = 32'(r_bypass);
            default:           prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign limit      = {r_frames, {FRAC_W{1'b0}}};
    assign phase_sum  = (PW+1)'(r_phase) + (PW+1)'(r_step);
    assign phase_next = phase_sum[PW] ? {PW{1'b1}} : phase_sum[PW-1:0];

    assign rnd     = (PRODW+1)'(r_prod) + (PRODW+1)'(32768);
    assign total   = rnd[PRODW:16];
    assign total_e = (total == '0) ? KW'(1) : KW'(total);
    assign kdiff   = (total_e > KW'(r_sent)) ? total_e - KW'(r_sent) : KW'(1);

    always_comb begin
        want      = 1'b0;
        last_flag = 1'b0;
        if (r_state == S_EMIT) begin
            if (r_byp_item) begin
                want      = 1'b1;
                last_flag = r_last_in;
            end else if (r_last_item) begin
                want      = 1'b1;
                last_flag = (CNT_W'(r_cnt + CNT_W'(1)) == r_k);
            end else begin
                want = (r_cnt < CNT_W'(MAX_RESULTS)) && (r_phase < limit);
            end
        end
    end

    assign emit_ctl.load = want && m_free;
    assign emit_ctl.last = last_flag;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_bypass || !s_axis_tlast) n_state = S_EMIT;
                    else n_state = S_PROD;
                end
            end
            S_PROD:  n_state = S_KCALC;
            S_KCALC: n_state = S_EMIT;
            S_EMIT: begin
                if (r_byp_item || r_last_item) begin
                    if (emit_ctl.load && (r_byp_item || last_flag)) n_state = S_IDLE;
                end else if (!want) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_frames    <= '0;
            r_sent      <= '0;
            r_cnt       <= '0;
            r_byp_item  <= 1'b0;
            r_last_item <= 1'b0;
            for (int c = 0; c < MAX_CHANNELS; c++) r_prev[c] <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_byp_item  <= r_bypass;
                r_last_item <= s_axis_tlast && !r_bypass;
                r_cnt       <= '0;
                // The first frame of a stream is its own predecessor.
                if (!r_bypass && r_frames == '0) begin
                    for (int c = 0; c < MAX_CHANNELS; c++)
                        r_prev[c] <= s_axis_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
                end
            end
            if (r_state == S_EMIT && !r_byp_item) begin
                if (r_last_item) begin
                    if (emit_ctl.load) begin
                        if (last_flag) begin
                            r_phase  <= '0;
                            r_frames <= '0;
                            r_sent   <= '0;
                            for (int c = 0; c < MAX_CHANNELS; c++) r_prev[c] <= '0;
                        end else begin
                            r_phase <= phase_next;
                            r_sent  <= (r_sent == {SENT_W{1'b1}}) ? r_sent : r_sent + 1'b1;
                        end
                        r_cnt <= r_cnt + 1'b1;
                    end
                end else if (want) begin
                    if (emit_ctl.load) begin
                        r_phase <= phase_next;
                        r_sent  <= (r_sent == {SENT_W{1'b1}}) ? r_sent : r_sent + 1'b1;
                        r_cnt   <= r_cnt + 1'b1;
                    end
                end else begin
                    for (int c = 0; c < MAX_CHANNELS; c++) r_prev[c] <= r_cur[c];
                    if (r_frames != {FW{1'b1}}) r_frames <= r_frames + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_last_in <= s_axis_tlast;
            for (int c = 0; c < MAX_CHANNELS; c++)
                r_cur[c] <= s_axis_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
        end
        if (r_state == S_PROD)
            r_prod <= PRODW'(({1'b0, r_frames} + (FW+1)'(1))) * PRODW'(r_scale);
        if (r_state == S_KCALC)
            r_k <= (kdiff > KW'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : kdiff[CNT_W-1:0];
    end

    // ---------------- channel lanes ----------------
    for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
        logic signed [SAMPLE_BITS-1:0] a_in;
        logic signed [SAMPLE_BITS-1:0] y;

        // In bypass both ends of the blend are the current frame.
        assign a_in = r_byp_item ? r_cur[c] : r_prev[c];
        assign lane_en[c] = (c == 0) || (r_chan > CHAN_W'(c));

        lir_lane #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_lane (
            .i_prev  (a_in),
            .i_cur   (r_cur[c]),
            .i_weight(r_phase[FRAC_W-1:0]),
            .o_sample(y)
        );

        assign lane_y[c*SAMPLE_BITS +: SAMPLE_BITS] = y;
    end

    lir_merge #(
        .MAX_CHANNELS(MAX_CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .TDATA_W     (TDW)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (emit_ctl),
        .i_lane_en  (lane_en),
        .i_lane_data(lane_y),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_data     (m_axis_tdata),
        .o_last     (m_axis_tlast),
        .o_free     (m_free)
    );

`ifndef SYNTHESIS
    // A result is never loaded over one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_ctl.load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten");

    // The flagged result of a final frame restarts the stream.
    a_stream_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_ctl.load && emit_ctl.last && r_last_item && r_state == S_EMIT)
        |=> (r_frames == '0 && r_phase == '0 && r_sent == '0))
        else $error("stream state not cleared after final output");

    // A bypassed item leaves the stream state alone.
    a_bypass_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_byp_item)
        |=> ($stable(r_frames) && $stable(r_phase) && $stable(r_sent)))
        else $error("bypass item changed stream state");
`endif

endmodule
